// File: hdl/ist_pkg.sv
// Interval statistics package: request/result structs, opcodes, snapshot type.
// No dependencies.
`default_nettype none
package ist_pkg;

    localparam int unsigned IST_SAMPLE_BITS = 32;
    localparam int unsigned IST_ACC_BITS    = 64;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_REPORT = 2'd2,
        OP_NONE   = 2'd3
    } ist_op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] sample;
    } item_t;

    typedef struct packed {
        logic [31:0] sample_count;
        logic [31:0] minimum;
        logic [31:0] maximum;
        logic [31:0] mean;
        logic [31:0] variance;
        logic [15:0] std_dev;
    } result_t;

    // Accumulator snapshot handed from front to back
    typedef struct packed {
        logic [IST_ACC_BITS-1:0] sum;
        logic [IST_ACC_BITS-1:0] sumsq;
        logic [31:0]             count;
        logic [31:0]             smallest;
        logic [31:0]             largest;
    } ist_snap_t;

endpackage
`default_nettype wire

// File: hdl/ist_front.sv
// Front end: accepts requests, squares samples, keeps the accumulators and
// pushes a snapshot per report. Depends on ist_pkg.
`default_nettype none
module ist_front
    import ist_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = IST_SAMPLE_BITS
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_ready,
    input  wire item_t     item,
    output logic           snap_push,
    input  wire logic      snap_ready,
    output ist_snap_t      snap
);

    logic                       s1_valid_reg, s2_valid_reg;
    logic [1:0]                 s1_op_reg, s2_op_reg;
    logic [SAMPLE_BITS-1:0]     s1_sample_reg, s2_sample_reg;
    logic [2*SAMPLE_BITS-1:0]   s2_sq_reg;
    logic [IST_ACC_BITS-1:0]    sum_reg, sum_next, sumsq_reg, sumsq_next;
    logic [31:0]                count_reg, count_next;
    logic [31:0]                min_reg, min_next, max_reg, max_next;
    logic [31:0]                s2_wide;
    logic                       adv;

    // whole pipe holds while a report waits for queue space
    assign adv        = !(s2_valid_reg && (s2_op_reg == OP_REPORT) && !snap_ready);
    assign item_ready = adv;
    assign snap_push  = s2_valid_reg && (s2_op_reg == OP_REPORT) && snap_ready;
    assign snap       = '{sum: sum_reg, sumsq: sumsq_reg, count: count_reg,
                          smallest: min_reg, largest: max_reg};
    assign s2_wide    = 32'(s2_sample_reg);

    always_comb
    begin
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        count_next = count_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        if (s2_valid_reg && adv)
        begin
            unique case (s2_op_reg)
                OP_ADD:
                begin
                    sum_next   = sum_reg + IST_ACC_BITS'(s2_sample_reg);
                    sumsq_next = sumsq_reg + IST_ACC_BITS'(s2_sq_reg);
                    count_next = count_reg + 32'd1;
                    if (s2_wide < min_reg) min_next = s2_wide;
                    if (s2_wide > max_reg) max_next = s2_wide;
                end
                OP_CLEAR:
                begin
                    sum_next   = '0;
                    sumsq_next = '0;
                    count_next = '0;
                    min_next   = '1;
                    max_next   = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sum_reg      <= '0;
            sumsq_reg    <= '0;
            count_reg    <= '0;
            min_reg      <= '1;
            max_reg      <= '0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= item_valid;
                s2_valid_reg <= s1_valid_reg;
            end
            sum_reg   <= sum_next;
            sumsq_reg <= sumsq_next;
            count_reg <= count_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg     <= item.operation;
            s1_sample_reg <= item.sample[SAMPLE_BITS-1:0];
            s2_op_reg     <= s1_op_reg;
            s2_sample_reg <= s1_sample_reg;
            s2_sq_reg     <= s1_sample_reg * s1_sample_reg;
        end
    end

endmodule
`default_nettype wire

// File: hdl/ist_queue.sv
// Two-entry snapshot queue between front and back. Depends on ist_pkg.
`default_nettype none
module ist_queue
    import ist_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    output logic           push_ready,
    input  wire ist_snap_t push_data,
    output logic           pop_valid,
    input  wire logic      pop,
    output ist_snap_t      pop_data
);

    ist_snap_t   mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  fill_reg;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// File: hdl/ist_back.sv
// Back end: bit-serial divides for mean and mean square, a square, the
// subtract and a bitwise root; holds the result register. Depends on ist_pkg.
`default_nettype none
module ist_back
    import ist_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      snap_valid,
    output logic           snap_pop,
    input  wire ist_snap_t snap,
    output logic           result_valid,
    input  wire logic      result_ready,
    output result_t        result
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIVM = 7'b0000010,
        S_DIVV = 7'b0000100,
        S_SQ   = 7'b0001000,
        S_SUB  = 7'b0010000,
        S_ROOT = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    ist_snap_t       snap_reg;
    logic [63:0]     dq_reg;
    logic [32:0]     rem_reg;
    logic [5:0]      cnt_reg;
    logic [31:0]     mean_reg, msq_reg, sq_reg, var_reg;
    logic [15:0]     root_reg, bit_reg;
    logic            res_valid_reg;
    result_t         res_reg;

    logic [32:0]     shifted;
    logic            ge;
    logic [63:0]     quot;
    logic [15:0]     trial;
    logic [31:0]     trial_sq;
    logic            out_free;

    assign shifted  = {rem_reg[31:0], dq_reg[63]};
    assign ge       = (shifted >= {1'b0, snap_reg.count});
    assign quot     = {dq_reg[62:0], ge};
    assign trial    = root_reg | bit_reg;
    assign trial_sq = trial * trial;
    assign out_free = !res_valid_reg || result_ready;

    assign snap_pop     = (state_reg == S_IDLE) && snap_valid;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (snap_valid) state_next = S_DIVM;
            S_DIVM: if (cnt_reg == 6'd63) state_next = S_DIVV;
            S_DIVV: if (cnt_reg == 6'd63) state_next = S_SQ;
            S_SQ:   state_next = S_SUB;
            S_SUB:  state_next = S_ROOT;
            S_ROOT: if (bit_reg[0]) state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT && out_free)
                res_valid_reg <= 1'b1;
            else if (result_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                snap_reg <= snap;
                dq_reg   <= snap.sum;
                rem_reg  <= '0;
                cnt_reg  <= '0;
            end
            S_DIVM, S_DIVV:
            begin
                rem_reg <= ge ? (shifted - {1'b0, snap_reg.count}) : shifted;
                dq_reg  <= quot;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    rem_reg <= '0;
                    dq_reg  <= snap_reg.sumsq;
                    if (state_reg == S_DIVM)
                        mean_reg <= (snap_reg.count == 32'd0) ? 32'd0 : quot[31:0];
                    else
                        msq_reg <= quot[31:0];
                end
            end
            S_SQ:
                sq_reg <= 32'(mean_reg * mean_reg);
            S_SUB:
            begin
                // only the low word of the difference is reported
                var_reg  <= (snap_reg.count < 32'd2) ? 32'd0 : (msq_reg - sq_reg);
                root_reg <= '0;
                bit_reg  <= 16'h8000;
            end
            S_ROOT:
            begin
                if (var_reg >= trial_sq) root_reg <= trial;
                bit_reg <= bit_reg >> 1;
            end
            S_OUT:
                if (out_free)
                    res_reg <= '{sample_count: snap_reg.count,
                                 minimum:      snap_reg.smallest,
                                 maximum:      snap_reg.largest,
                                 mean:         mean_reg,
                                 variance:     var_reg,
                                 std_dev:      root_reg};
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/interval_statistics.sv
// Interval statistics top level: front end, snapshot queue, back end.
// Depends on ist_pkg, ist_front, ist_queue, ist_back.
//
// Usage
//   Requests enter on item_valid/item_ready with an item_t payload:
//   add a sample, clear the statistics, or report. Only reports produce a
//   result, delivered on result_valid/result_ready as a result_t.
//   Operation code 3 is dropped without effect.
// Data path
//   Add and clear requests are taken one per cycle while the front is not
//   stalled; they pass a two-stage front pipe (register, then square) and
//   update the accumulators. A report snapshots the accumulators into a
//   two-entry queue. The back end works one report at a time: two 64-step
//   bit-serial divides (sum/n, sumsq/n), a square, a subtract and a
//   16-step root.
// Reset
//   rst_n clears the accumulators (minimum to all ones), empties the queue
//   and drops any pending result.
// Stalls
//   A waiting result is held in an output register while the back end
//   starts the next report. With the queue full, the front stalls on the
//   next report and item_ready falls until a slot frees.
`default_nettype none
module interval_statistics
    import ist_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = IST_SAMPLE_BITS
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_ready,
    input  wire item_t item,
    output logic       result_valid,
    input  wire logic  result_ready,
    output result_t    result
);

    logic      push, push_ready, pop, pop_valid;
    ist_snap_t push_data, pop_data;

    ist_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .snap_push  (push),
        .snap_ready (push_ready),
        .snap       (push_data)
    );

    ist_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    ist_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .snap_valid   (pop_valid),
        .snap_pop     (pop),
        .snap         (pop_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
`default_nettype wire

// File: hdl/ist_chk.sv
// Port-level checker for interval_statistics, bound to the top level.
// Depends on ist_pkg.
`default_nettype none
module ist_chk
    import ist_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_valid,
    input wire logic    item_ready,
    input wire item_t   item,
    input wire logic    result_valid,
    input wire logic    result_ready,
    input wire result_t result
);

    logic [3:0] pend_reg;
    logic       rep_in, res_out;

    assign rep_in  = item_valid && item_ready && (item.operation == OP_REPORT);
    assign res_out = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_reg + 4'(rep_in) - 4'(res_out);
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result dropped or changed while stalled");

    a_owed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pend_reg != 4'd0)
        else $error("result without an outstanding report");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.sample_count != 32'd0 |->
            result.minimum <= result.maximum)
        else $error("minimum above maximum");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.sample_count == 32'd0 |->
            result.mean == 32'd0 && result.variance == 32'd0 &&
            result.std_dev == 16'd0)
        else $error("empty set reports non-zero statistics");

endmodule

bind interval_statistics ist_chk u_ist_chk (.*);
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for interval_statistics: sends add, clear and report requests,
// predicts each report result and compares the whole result against it. Depends on ist_pkg and the RTL.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ist_pkg::*;

    localparam int unsigned IDLE_PCT   = 16;
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned REPORT_CYCLES = 160;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    interval_statistics dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state: mirrors the block's accumulators
    logic [63:0] acc_sum;
    logic [63:0] acc_sumsq;
    logic [31:0] acc_count;
    logic [31:0] acc_min;
    logic [31:0] acc_max;

    result_t expected_reports[$];
    int      mismatches = 0;
    bit      calm = 1'b0;      // no random idling on either side
    bit      hold_results = 1'b0;
    int      quiet_cycles = 0;

    function automatic logic [15:0] root16(input logic [31:0] v);
        logic [31:0] r;
        logic [31:0] t;
        r = '0;
        for (int k = 15; k >= 0; k--)
        begin
            t = r | (32'd1 << k);
            if ({32'd0, v} >= {32'd0, t} * {32'd0, t})
                r = t;
        end
        return r[15:0];
    endfunction

    task automatic clear_stats();
        acc_sum = '0;
        acc_sumsq = '0;
        acc_count = '0;
        acc_min = '1;
        acc_max = '0;
    endtask

    // Apply one accepted request to the predictor
    task automatic predict(input item_t req);
        result_t     r;
        logic [63:0] avg;
        logic [63:0] msq;
        case (ist_op_t'(req.operation))
            OP_ADD:
            begin
                acc_sum   += {32'd0, req.sample};
                acc_sumsq += {32'd0, req.sample} * {32'd0, req.sample};
                acc_count += 1;
                if (req.sample < acc_min) acc_min = req.sample;
                if (req.sample > acc_max) acc_max = req.sample;
            end
            OP_CLEAR: clear_stats();
            OP_REPORT:
            begin
                avg = '0;
                r = '0;
                if (acc_count != 0)
                    avg = acc_sum / {32'd0, acc_count};
                if (acc_count >= 2)
                begin
                    msq = acc_sumsq / {32'd0, acc_count};
                    r.variance = 32'(msq - avg * avg);
                end
                r.sample_count = acc_count;
                r.minimum = acc_min;
                r.maximum = acc_max;
                r.mean = avg[31:0];
                r.std_dev = root16(r.variance);
                expected_reports.push_back(r);
            end
            default: ;
        endcase
    endtask

    // Send one request; valid stays up until accepted, drops only when idling
    task automatic send(input ist_op_t op, input logic [31:0] s);
        if (!calm)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
        item_valid <= 1'b1;
        item <= '{operation: op, sample: s};
        do
            @(posedge clk);
        while (!item_ready);
        predict('{operation: op, sample: s});
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_results)
            result_ready <= 1'b0;
        else
            result_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Result checker
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                e = expected_reports.pop_front();
                if (result !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", e, result);
                end
            end
        end
    end

    // Watchdog: cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic test_empty_and_single();
        send(OP_REPORT, 32'd0);
        send(OP_ADD, 32'hFFFF_FFFF);
        send(OP_REPORT, 32'd0);
        send(OP_NONE, 32'h1234_5678);   // ignored code
        send(OP_REPORT, 32'd0);
    endtask

    task automatic test_extremes();
        send(OP_CLEAR, 32'hFFFF_FFFF);
        send(OP_ADD, 32'd0);
        send(OP_ADD, 32'hFFFF_FFFF);
        send(OP_REPORT, 32'hFFFF_FFFF);
        send(OP_ADD, 32'h8000_0000);
        send(OP_ADD, 32'h7FFF_FFFF);
        send(OP_REPORT, 32'd0);
        send(OP_CLEAR, 32'd0);
        send(OP_ADD, 32'd5);
        send(OP_ADD, 32'd5);
        send(OP_REPORT, 32'd0);
        send(OP_ADD, 32'd1);
        send(OP_ADD, 32'd9);
        send(OP_REPORT, 32'd0);
    endtask

    // Many huge samples so the sum of squares wraps and the variance underflows
    task automatic test_wrap();
        send(OP_CLEAR, 32'd0);
        for (int i = 0; i < 6; i++)
            send(OP_ADD, 32'hFFFF_FFFF);
        send(OP_ADD, 32'd3);
        send(OP_REPORT, 32'd0);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(1000);
            2: return 32'd100000 + $urandom_range(5000);
            default: return $urandom() | 32'hF000_0000;
        endcase
    endfunction

    task automatic test_random(input int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 78)      send(OP_ADD, rand_sample());
            else if (k < 93) send(OP_REPORT, $urandom());
            else if (k < 97) send(OP_CLEAR, $urandom());
            else             send(OP_NONE, $urandom());
        end
    endtask

    // Receiver holds off while reports pile up and stall the input
    task automatic test_backpressure();
        hold_results = 1'b1;
        fork
            begin
                repeat (2000) @(posedge clk);
                hold_results = 1'b0;
            end
            for (int i = 0; i < 8; i++)
            begin
                send(OP_ADD, rand_sample());
                send(OP_REPORT, 32'd0);
            end
        join
    endtask

    initial
    begin
        clear_stats();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_single();
        test_extremes();
        test_wrap();
        drain();                      // sender pauses until all results are in
        test_random(250);
        calm = 1'b1;
        test_random(150);
        calm = 1'b0;
        test_backpressure();
        test_random(200);
        drain();
        repeat (REPORT_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
